// File: sv/fdcr_pkg.sv
// shared types, constants and helper functions of the floppy controller register unit
`default_nettype none

package fdcr_pkg;

  localparam int MaxDrives  = 4;
  localparam int ResultDepth = 8;
  localparam int ParamDepth  = 4;

  localparam int DrvW  = 2;
  localparam int RidxW = $clog2(ResultDepth);
  localparam int PidxW = $clog2(ParamDepth);
  localparam int CntW  = $clog2(ResultDepth + 1);
  localparam int RecvW = $clog2(ParamDepth + 1);

  typedef enum logic [2:0] {
    ModeRead   = 3'd0,
    ModeWrite  = 3'd1,
    ModeChange = 3'd2,
    ModeAck    = 3'd3,
    ModeReset  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    RegDor  = 3'd0,
    RegMsr  = 3'd1,
    RegData = 3'd2,
    RegDir  = 3'd3
  } reg_sel_e;

  typedef enum logic [4:0] {
    CmdSpecify   = 5'h03,
    CmdSenseDrv  = 5'h04,
    CmdRecal     = 5'h07,
    CmdSenseInt  = 5'h08,
    CmdReadId    = 5'h0A,
    CmdSeek      = 5'h0F,
    CmdVersion   = 5'h10,
    CmdConfigure = 5'h13
  } cmd_code_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] register_select;
    logic [7:0] write_data;
    logic [1:0] drive;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       drive_changed_flag;
  } out_item_t;

  typedef struct packed {
    logic [CntW-1:0] res_count;
    logic [CntW-1:0] rd_pos;
  } status_t;

  // number of parameter bytes that follow a command byte
  function automatic logic [1:0] params_for(input logic [7:0] cmd);
    logic [1:0] n;
    unique case (cmd[4:0])
      CmdSpecify, CmdSeek:             n = 2'd2;
      CmdSenseDrv, CmdRecal, CmdReadId: n = 2'd1;
      CmdConfigure:                    n = 2'd3;
      default:                         n = 2'd0;
    endcase
    return n;
  endfunction

  // drive below the effective drive count
  function automatic logic drv_ok(input logic [DrvW-1:0] d, input logic [2:0] n);
    logic [2:0] e;
    e = (n == 3'd0) ? 3'd1 : n;
    if (e > 3'(MaxDrives)) e = 3'(MaxDrives);
    return {1'b0, d} < e;
  endfunction

  // register value saturated to the drive limit
  function automatic logic [2:0] sat_count(input logic [2:0] v);
    return (v > 3'(MaxDrives)) ? 3'(MaxDrives) : v;
  endfunction

endpackage

`default_nettype wire

// File: sv/floppy_disk_controller_registers_unit.sv
// a transaction waits in the input register, and its result is registered in the output register
// throughput: one transaction per cycle while results are taken from the output register
// an empty input register fills while a finished result waits in the output register
// reset: asynchronous active low; clears all controller state, drive count returns to one
// configuration writes are taken in any cycle and saturate the drive count at four
`default_nettype none

module floppy_disk_controller_registers_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire fdcr_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output fdcr_pkg::out_item_t      out_item_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_data_i
);
  import fdcr_pkg::*;

  // input register
  logic      in_v_q;
  in_item_t  in_q;
  // output register
  logic      out_v_q;
  out_item_t out_q;

  out_item_t result;
  status_t   status;
  logic      advance;

  // the held transaction moves on whenever the output register is free or being emptied
  assign advance     = in_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o  = !in_v_q || advance;
  assign cfg_ready_o = 1'b1;

  fdcr_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (in_q),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (result),
    .status_o   (status)
  );

  // valid flags of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) in_v_q <= in_valid_i;
      if (advance) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_item_i;
    if (advance) out_q <= result;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  // with the output side free, input is always open
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // a held transaction that advances must produce a result
  a_advance_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("advanced transaction produced no result");

  // read position stays inside the result queue, or both are cleared
  a_queue_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.rd_pos < status.res_count) ||
    (status.rd_pos == '0 && status.res_count == '0))
    else $error("result read position outside the queue");

  // the queue never holds more bytes than its depth
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.res_count <= CntW'(ResultDepth))
    else $error("result count above queue depth");

endmodule

`default_nettype wire

// File: sv/fdcr_core.sv
// controller state, command decode and command execution for one transaction a cycle when stepped
`default_nettype none

module fdcr_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire fdcr_pkg::in_item_t item_i,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_data_i,
  output fdcr_pkg::out_item_t    result_o,
  output fdcr_pkg::status_t      status_o
);
  import fdcr_pkg::*;

  logic [2:0]       dc_q, dc_d;
  logic [7:0]       dov_q, dov_d;
  logic [DrvW-1:0]  sel_q, sel_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [1:0]       exp_q, exp_d;
  logic [RecvW-1:0] recv_q, recv_d;
  logic [7:0]       pstore_q [ParamDepth];
  logic [7:0]       pstore_d [ParamDepth];
  logic [7:0]       rstore_q [ResultDepth];
  logic [7:0]       rstore_d [ResultDepth];
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic             flags_q [MaxDrives];
  logic             flags_d [MaxDrives];
  logic [7:0]       cyl_q [MaxDrives];
  logic [7:0]       cyl_d [MaxDrives];
  logic             ip_q, ip_d;
  logic [DrvW-1:0]  idrv_q, idrv_d;
  logic [7:0]       rd;

  always_comb begin
    logic [4:0]       code;
    logic [DrvW-1:0]  d;
    logic [RecvW-1:0] taken;
    logic             run;
    logic             raise;
    logic [7:0]       rv [ResultDepth];
    logic [CntW-1:0]  rn;
    logic [CntW-1:0]  pos_inc;

    dc_d     = dc_q;
    dov_d    = dov_q;
    sel_d    = sel_q;
    cmd_d    = cmd_q;
    exp_d    = exp_q;
    recv_d   = recv_q;
    pstore_d = pstore_q;
    rstore_d = rstore_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    flags_d  = flags_q;
    cyl_d    = cyl_q;
    ip_d     = ip_q;
    idrv_d   = idrv_q;
    rd       = 8'h00;
    run      = 1'b0;
    raise    = 1'b0;
    taken    = '0;
    rn       = '0;
    pos_inc  = '0;
    code     = 5'd0;
    d        = sel_q;
    for (int i = 0; i < ResultDepth; i++) rv[i] = 8'h00;

    if (cfg_we_i) dc_d = sat_count(cfg_data_i);

    if (step_i) begin
      unique case (item_i.mode)
        ModeRead: begin
          unique case (item_i.register_select)
            RegDor: rd = dov_q;
            RegMsr: rd = (pos_q < cnt_q) ? 8'hC0 : 8'h80;
            RegData: begin
              if (pos_q < cnt_q && pos_q < CntW'(ResultDepth)) begin
                rd      = rstore_q[pos_q[RidxW-1:0]];
                pos_inc = pos_q + 1'b1;
                if (pos_inc >= cnt_q) begin
                  pos_d = '0;
                  cnt_d = '0;
                end else begin
                  pos_d = pos_inc;
                end
              end
            end
            RegDir: rd = (drv_ok(sel_q, dc_q) && flags_q[sel_q]) ? 8'h80 : 8'h00;
            default: rd = 8'hFF;
          endcase
        end
        ModeWrite: begin
          unique case (item_i.register_select)
            RegDor: begin
              dov_d = item_i.write_data;
              sel_d = item_i.write_data[DrvW-1:0];
            end
            RegData: begin
              if (exp_q != 2'd0) begin
                if (recv_q < RecvW'(ParamDepth)) begin
                  pstore_d[recv_q[PidxW-1:0]] = item_i.write_data;
                  recv_d = recv_q + 1'b1;
                end
                taken = recv_d;
                if (recv_d >= RecvW'(exp_q)) run = 1'b1;
              end else begin
                cmd_d  = item_i.write_data;
                exp_d  = params_for(item_i.write_data);
                recv_d = '0;
                taken  = '0;
                if (exp_d == 2'd0) run = 1'b1;
              end
            end
            default: ;
          endcase
        end
        ModeChange: begin
          if (drv_ok(item_i.drive, dc_q)) begin
            flags_d[item_i.drive] = 1'b1;
            cyl_d[item_i.drive]   = 8'h00;
            ip_d   = 1'b1;
            idrv_d = item_i.drive;
          end
        end
        ModeAck: begin
          if (drv_ok(item_i.drive, dc_q)) flags_d[item_i.drive] = 1'b0;
        end
        ModeReset: begin
          dov_d  = '0;
          sel_d  = '0;
          cmd_d  = '0;
          exp_d  = '0;
          recv_d = '0;
          cnt_d  = '0;
          pos_d  = '0;
          ip_d   = 1'b0;
          idrv_d = '0;
          for (int i = 0; i < ParamDepth; i++) pstore_d[i] = 8'h00;
          for (int i = 0; i < ResultDepth; i++) rstore_d[i] = 8'h00;
          for (int i = 0; i < MaxDrives; i++) begin
            flags_d[i] = 1'b0;
            cyl_d[i]   = 8'h00;
          end
          if (dc_q == 3'd0) dc_d = 3'd1;
        end
        default: ;
      endcase
    end

    // command execution once the last parameter is in, or at once for a command without parameters
    if (run) begin
      code   = cmd_d[4:0];
      d      = (taken != '0) ? pstore_d[0][DrvW-1:0] : sel_q;
      cnt_d  = '0;
      pos_d  = '0;
      exp_d  = '0;
      recv_d = '0;
      unique case (code)
        CmdSenseInt: begin
          rv[0] = {2'b00, ip_q, 3'b000, idrv_q};
          rv[1] = drv_ok(idrv_q, dc_q) ? cyl_q[idrv_q] : 8'h00;
          rn    = CntW'(2);
          ip_d  = 1'b0;
        end
        CmdSenseDrv: begin
          rv[0] = {2'b00, 1'b1, (drv_ok(d, dc_q) && cyl_q[d] == 8'h00), 2'b00, d};
          rn    = CntW'(1);
        end
        CmdRecal: begin
          if (drv_ok(d, dc_q)) cyl_d[d] = 8'h00;
          raise = 1'b1;
        end
        CmdSeek: begin
          if (taken >= RecvW'(2) && drv_ok(d, dc_q)) cyl_d[d] = pstore_d[1];
          raise = 1'b1;
        end
        CmdReadId: begin
          rv[3] = drv_ok(d, dc_q) ? cyl_q[d] : 8'h00;
          rv[5] = 8'h01;
          rv[6] = 8'h02;
          rn    = CntW'(7);
        end
        CmdVersion: begin
          rv[0] = 8'h80;
          rn    = CntW'(1);
        end
        default: ;
      endcase
      if (raise) begin
        if (drv_ok(d, dc_q)) flags_d[d] = 1'b0;
        ip_d   = 1'b1;
        idrv_d = d;
      end
      for (int i = 0; i < ResultDepth; i++) begin
        if (CntW'(i) < rn) rstore_d[i] = rv[i];
      end
      cnt_d = rn;
    end
  end

  assign result_o.read_data          = rd;
  assign result_o.drive_changed_flag = drv_ok(item_i.drive, dc_d) && flags_d[item_i.drive];
  assign status_o.res_count          = cnt_q;
  assign status_o.rd_pos             = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q   <= 3'd1;
      dov_q  <= '0;
      sel_q  <= '0;
      cmd_q  <= '0;
      exp_q  <= '0;
      recv_q <= '0;
      cnt_q  <= '0;
      pos_q  <= '0;
      ip_q   <= 1'b0;
      idrv_q <= '0;
      for (int i = 0; i < ParamDepth; i++) pstore_q[i] <= 8'h00;
      for (int i = 0; i < ResultDepth; i++) rstore_q[i] <= 8'h00;
      for (int i = 0; i < MaxDrives; i++) begin
        flags_q[i] <= 1'b0;
        cyl_q[i]   <= 8'h00;
      end
    end else begin
      dc_q     <= dc_d;
      dov_q    <= dov_d;
      sel_q    <= sel_d;
      cmd_q    <= cmd_d;
      exp_q    <= exp_d;
      recv_q   <= recv_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
      ip_q     <= ip_d;
      idrv_q   <= idrv_d;
      pstore_q <= pstore_d;
      rstore_q <= rstore_d;
      flags_q  <= flags_d;
      cyl_q    <= cyl_d;
    end
  end

endmodule

`default_nettype wire
